// File: sv/mxp_pkg.sv
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Shared widths, reset values, register indexes and state codes.
// ----------------------------------------------------------------------------
package mxp_pkg;

    // Field widths
    localparam int MSG_W        = 32;
    localparam int EXP_W        = 32;
    localparam int MOD_W        = 31;
    localparam int MUL_BITS_DEF = 32;

    // Configuration port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Register reset values
    localparam logic [EXP_W-1:0] ENC_EXP_RST = EXP_W'(11);
    localparam logic [MOD_W-1:0] ENC_MOD_RST = MOD_W'(84823);
    localparam logic [EXP_W-1:0] DEC_EXP_RST = EXP_W'(27103);
    localparam logic [MOD_W-1:0] DEC_MOD_RST = MOD_W'(95477);

    // Register indexes (word address)
    typedef enum logic [1:0] {
        REG_ENC_EXP = 2'd0,
        REG_ENC_MOD = 2'd1,
        REG_DEC_EXP = 2'd2,
        REG_DEC_MOD = 2'd3
    } t_reg_idx;

    // Operation codes
    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    // Key set handed from the register file to the core
    typedef struct packed {
        logic [EXP_W-1:0] enc_exp;
        logic [MOD_W-1:0] enc_mod;
        logic [EXP_W-1:0] dec_exp;
        logic [MOD_W-1:0] dec_mod;
    } t_keys;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RED_GO,
        ST_RED_RUN,
        ST_MUL_GO,
        ST_MUL_RUN,
        ST_FIN
    } t_state;

endpackage

// File: sv/mxp_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying the operation and the message.
// ----------------------------------------------------------------------------
interface mxp_req_if;
    logic                     valid;
    logic                     ready;
    logic                     op;
    logic [mxp_pkg::MSG_W-1:0] message;

    modport source (output valid, output op, output message, input ready);
    modport sink   (input valid, input op, input message, output ready);
endinterface

// File: sv/mxp_rsp_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying the exponentiation result.
// ----------------------------------------------------------------------------
interface mxp_rsp_if;
    logic                     valid;
    logic                     ready;
    logic [mxp_pkg::MOD_W-1:0] result;

    modport source (output valid, output result, input ready);
    modport sink   (input valid, input result, output ready);
endinterface

// File: sv/modular_exponentiation_core.sv
// ----------------------------------------------------------------------------
// Modular exponentiation core
// Raises the message to the selected key's exponent modulo its modulus by
// right-to-left square and multiply over two bit-serial multipliers.
// ----------------------------------------------------------------------------
// A zero exponent or a modulus below two goes straight to the result;
// otherwise the message is first reduced, then one multiply pass (the
// doubling/add loop of both multipliers) runs per exponent bit up to the
// highest set bit. One request is in flight at a time.
// Reset (synchronous, active low) loads the default keys and empties the core.
module modular_exponentiation_core #(
    parameter int MUL_BITS = mxp_pkg::MUL_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    mxp_req_if.sink                        i_req,
    mxp_rsp_if.source                      o_rsp,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mxp_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [mxp_pkg::APB_DATA_W-1:0] pwdata,
    output logic [mxp_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    mxp_pkg::t_keys keys;
    mxp_pkg::t_state r_state;
    mxp_pkg::t_state n_state;

    logic [mxp_pkg::EXP_W-1:0] sel_exp;
    logic [mxp_pkg::MOD_W-1:0] sel_mod;
    logic                      accept;
    logic                      trivial;
    logic                      req_ready;
    logic                      red_start;
    logic                      mul_start;
    logic                      fin_load;

    logic [mxp_pkg::EXP_W-1:0] r_exp;
    logic [mxp_pkg::MOD_W-1:0] r_mod;
    logic [mxp_pkg::MSG_W-1:0] r_msg;
    logic [mxp_pkg::MOD_W-1:0] r_acc;
    logic [mxp_pkg::MOD_W-1:0] r_run_a;
    logic [MUL_BITS-1:0]       r_run_b;
    logic                      r_out_valid;
    logic [mxp_pkg::MOD_W-1:0] r_out_result;

    logic                      red_done;
    logic [mxp_pkg::MOD_W-1:0] red_rem;
    logic                      acc_done;
    logic [mxp_pkg::MOD_W-1:0] acc_prod;
    logic                      sqr_done;
    logic [mxp_pkg::MOD_W-1:0] sqr_prod;

    // Key registers.
    mxp_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_keys    (keys)
    );

    // Message reduction ahead of the first squaring.
    mxp_modred u_red (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (red_start),
        .i_value (r_msg),
        .i_mod   (r_mod),
        .o_done  (red_done),
        .o_rem   (red_rem)
    );

    // Accumulator times running power.
    mxp_modmul #(.MUL_BITS(MUL_BITS)) u_mul_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (r_acc),
        .i_b     (r_run_b),
        .i_mod   (r_mod),
        .o_done  (acc_done),
        .o_prod  (acc_prod)
    );

    // Running power squared.
    mxp_modmul #(.MUL_BITS(MUL_BITS)) u_mul_sqr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (r_run_a),
        .i_b     (r_run_b),
        .i_mod   (r_mod),
        .o_done  (sqr_done),
        .o_prod  (sqr_prod)
    );

    // Key selection by operation.
    assign sel_exp = (i_req.op == mxp_pkg::OP_DECRYPT) ? keys.dec_exp : keys.enc_exp;
    assign sel_mod = (i_req.op == mxp_pkg::OP_DECRYPT) ? keys.dec_mod : keys.enc_mod;
    assign trivial = (sel_exp == '0) || (sel_mod[mxp_pkg::MOD_W-1:1] == '0);
    assign accept  = i_req.valid & req_ready;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mxp_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mxp_pkg::ST_IDLE: begin
                if (i_req.valid) begin
                    n_state = trivial ? mxp_pkg::ST_FIN : mxp_pkg::ST_RED_GO;
                end
            end
            mxp_pkg::ST_RED_GO:  n_state = mxp_pkg::ST_RED_RUN;
            mxp_pkg::ST_RED_RUN: begin
                if (red_done) begin
                    n_state = mxp_pkg::ST_MUL_GO;
                end
            end
            mxp_pkg::ST_MUL_GO:  n_state = mxp_pkg::ST_MUL_RUN;
            mxp_pkg::ST_MUL_RUN: begin
                if (acc_done) begin
                    n_state = (r_exp[mxp_pkg::EXP_W-1:1] == '0) ? mxp_pkg::ST_FIN
                                                                 : mxp_pkg::ST_MUL_GO;
                end
            end
            mxp_pkg::ST_FIN: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_state = mxp_pkg::ST_IDLE;
                end
            end
            default: n_state = mxp_pkg::ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        req_ready = 1'b0;
        red_start = 1'b0;
        mul_start = 1'b0;
        fin_load  = 1'b0;
        unique case (r_state)
            mxp_pkg::ST_IDLE:    req_ready = 1'b1;
            mxp_pkg::ST_RED_GO:  red_start = 1'b1;
            mxp_pkg::ST_MUL_GO:  mul_start = 1'b1;
            mxp_pkg::ST_FIN:     fin_load  = !r_out_valid || o_rsp.ready;
            default: ;
        endcase
    end

    // Exponentiation registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_exp <= sel_exp;
            r_mod <= sel_mod;
            r_msg <= i_req.message;
            // A zero exponent gives one, even with a modulus below two; otherwise a modulus below two gives zero.
            r_acc <= (sel_exp == '0) ? mxp_pkg::MOD_W'(1) : '0;
        end else if (r_state == mxp_pkg::ST_RED_RUN && red_done) begin
            r_acc   <= mxp_pkg::MOD_W'(1);
            r_run_a <= red_rem;
            r_run_b <= r_msg[MUL_BITS-1:0];
        end else if (r_state == mxp_pkg::ST_MUL_RUN && acc_done) begin
            if (r_exp[0]) begin
                r_acc <= acc_prod;
            end
            r_run_a <= sqr_prod;
            r_run_b <= MUL_BITS'(sqr_prod);
            r_exp   <= r_exp >> 1;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fin_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_load) begin
            r_out_result <= r_acc;
        end
    end

    assign i_req.ready  = req_ready;
    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.result = r_out_result;

    // Both multipliers start together and must finish together.
    a_mul_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_done == sqr_done)
        else $error("multiplier done pulses out of step");

    // Multiplying only happens with exponent bits left to scan.
    a_mul_exp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == mxp_pkg::ST_MUL_RUN |-> r_exp != '0)
        else $error("multiply running with exhausted exponent");

    // The multiplicand operands are reduced below the modulus.
    a_mul_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == mxp_pkg::ST_MUL_RUN |-> (r_acc < r_mod) && (r_run_a < r_mod))
        else $error("unreduced multiplicand");

    // The reduction unit reports only while it is awaited.
    a_red_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        red_done |-> r_state == mxp_pkg::ST_RED_RUN)
        else $error("unexpected reduction done");

endmodule

// File: sv/mxp_regs.sv
// ----------------------------------------------------------------------------
// Key register file
// APB-style write/read access to the two exponent/modulus key pairs.
// ----------------------------------------------------------------------------
module mxp_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_psel,
    input  logic                           i_penable,
    input  logic                           i_pwrite,
    input  logic [mxp_pkg::APB_ADDR_W-1:0] i_paddr,
    input  logic [mxp_pkg::APB_DATA_W-1:0] i_pwdata,
    output logic [mxp_pkg::APB_DATA_W-1:0] o_prdata,
    output logic                           o_pready,
    output mxp_pkg::t_keys                 o_keys
);

    logic              wr_en;
    mxp_pkg::t_reg_idx idx;
    mxp_pkg::t_keys    r_keys;

    assign o_pready = 1'b1;
    assign wr_en    = i_psel & i_penable & i_pwrite;
    assign idx      = mxp_pkg::t_reg_idx'(i_paddr[3:2]);

    // Register writes; the moduli keep only their low 31 bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keys.enc_exp <= mxp_pkg::ENC_EXP_RST;
            r_keys.enc_mod <= mxp_pkg::ENC_MOD_RST;
            r_keys.dec_exp <= mxp_pkg::DEC_EXP_RST;
            r_keys.dec_mod <= mxp_pkg::DEC_MOD_RST;
        end else if (wr_en) begin
            unique case (idx)
                mxp_pkg::REG_ENC_EXP: r_keys.enc_exp <= i_pwdata[mxp_pkg::EXP_W-1:0];
                mxp_pkg::REG_ENC_MOD: r_keys.enc_mod <= i_pwdata[mxp_pkg::MOD_W-1:0];
                mxp_pkg::REG_DEC_EXP: r_keys.dec_exp <= i_pwdata[mxp_pkg::EXP_W-1:0];
                mxp_pkg::REG_DEC_MOD: r_keys.dec_mod <= i_pwdata[mxp_pkg::MOD_W-1:0];
                default: ;
            endcase
        end
    end

    // Read-back mux.
    always_comb begin
        unique case (idx)
            mxp_pkg::REG_ENC_EXP: o_prdata = mxp_pkg::APB_DATA_W'(r_keys.enc_exp);
            mxp_pkg::REG_ENC_MOD: o_prdata = mxp_pkg::APB_DATA_W'(r_keys.enc_mod);
            mxp_pkg::REG_DEC_EXP: o_prdata = mxp_pkg::APB_DATA_W'(r_keys.dec_exp);
            mxp_pkg::REG_DEC_MOD: o_prdata = mxp_pkg::APB_DATA_W'(r_keys.dec_mod);
            default:              o_prdata = '0;
        endcase
    end

    assign o_keys = r_keys;

endmodule

// File: sv/mxp_modred.sv
// ----------------------------------------------------------------------------
// Bit-serial modular reduction
// Reduces a 32-bit value modulo m, one bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module mxp_modred (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [mxp_pkg::MSG_W-1:0] i_value,
    input  logic [mxp_pkg::MOD_W-1:0] i_mod,
    output logic                      o_done,
    output logic [mxp_pkg::MOD_W-1:0] o_rem
);

    localparam int CW = $clog2(mxp_pkg::MSG_W);
    localparam logic [CW-1:0] LAST = CW'(mxp_pkg::MSG_W - 1);

    logic [mxp_pkg::MSG_W-1:0] r_val;
    logic [mxp_pkg::MOD_W-1:0] r_rem;
    logic [mxp_pkg::MOD_W-1:0] n_rem;
    logic [CW-1:0]             r_cnt;
    logic                      r_busy;
    logic                      r_done;
    logic [mxp_pkg::MOD_W:0]   shifted;
    logic [mxp_pkg::MOD_W:0]   diff;

    // Shift the next message bit in; one compare and subtract keeps it below m.
    assign shifted = {r_rem, r_val[mxp_pkg::MSG_W-1]};
    assign diff    = shifted - {1'b0, i_mod};
    assign n_rem   = (shifted >= {1'b0, i_mod}) ? diff[mxp_pkg::MOD_W-1:0]
                                                : shifted[mxp_pkg::MOD_W-1:0];

    // Control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val <= i_value;
            r_rem <= '0;
        end else if (r_busy) begin
            r_val <= {r_val[mxp_pkg::MSG_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// File: sv/mxp_modmul.sv
// ----------------------------------------------------------------------------
// Bit-serial modular multiplier
// Computes a * b mod m over the low MUL_BITS bits of b, MSB first, with a
// doubling phase and an add phase for each bit of b.
// ----------------------------------------------------------------------------
module mxp_modmul #(
    parameter int MUL_BITS = mxp_pkg::MUL_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [mxp_pkg::MOD_W-1:0] i_a,
    input  logic [MUL_BITS-1:0]       i_b,
    input  logic [mxp_pkg::MOD_W-1:0] i_mod,
    output logic                      o_done,
    output logic [mxp_pkg::MOD_W-1:0] o_prod
);

    localparam int CW = $clog2(MUL_BITS);
    localparam logic [CW-1:0] LAST = CW'(MUL_BITS - 1);

    logic [mxp_pkg::MOD_W-1:0] r_a;
    logic [MUL_BITS-1:0]       r_b;
    logic [mxp_pkg::MOD_W-1:0] r_acc;
    logic [CW-1:0]             r_cnt;
    logic                      r_phase;
    logic                      r_busy;
    logic                      r_done;
    logic [mxp_pkg::MOD_W-1:0] addend;
    logic [mxp_pkg::MOD_W:0]   sum;
    logic [mxp_pkg::MOD_W:0]   diff;
    logic [mxp_pkg::MOD_W-1:0] n_acc;

    // Phase 0 doubles the accumulator, phase 1 adds a when the bit of b is set.
    always_comb begin
        if (r_phase) begin
            addend = r_b[MUL_BITS-1] ? r_a : '0;
        end else begin
            addend = r_acc;
        end
    end

    assign sum   = {1'b0, r_acc} + {1'b0, addend};
    assign diff  = sum - {1'b0, i_mod};
    assign n_acc = (sum >= {1'b0, i_mod}) ? diff[mxp_pkg::MOD_W-1:0]
                                          : sum[mxp_pkg::MOD_W-1:0];

    // Control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_phase <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_phase <= 1'b0;
                r_cnt   <= '0;
            end else if (r_busy) begin
                r_phase <= ~r_phase;
                if (r_phase) begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == LAST) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end
            end
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= n_acc;
            if (r_phase) begin
                r_b <= {r_b[MUL_BITS-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule
